// File: rtl/vehicle_video_rtp_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// vehicle video rtp deframer assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef VEHICLE_VIDEO_RTP_DEFRAMER_CORE_MACROS_SVH
`define VEHICLE_VIDEO_RTP_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define VVRD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vvrd same-cycle check failed");

// next-cycle implication
`define VVRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vvrd next-cycle check failed");

`endif

// File: rtl/vvrd_pkg.sv
// ----------------------------------------------------------------------------
// vvrd_pkg
// shared types and constants of the rtp deframer
// ----------------------------------------------------------------------------
package vvrd_pkg;

    // result kinds, plus one internal code for a stored header byte
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_BAD_HDR  = 3'd2;
    localparam logic [2:0] KIND_BAD_TYPE = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG = 3'd4;
    localparam logic [2:0] KIND_ABORTED  = 3'd5;
    localparam logic [2:0] TOK_HDR_BYTE  = 3'd6;

    // configuration register indexes
    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_MAX_LEN   = 1'b1;

    // configuration reset values
    localparam logic [31:0] SYNC_WORD_RST = 32'h3031_6364;
    localparam logic [15:0] MAX_LEN_RST   = 16'hffff;

    // audio data type code
    localparam logic [1:0] DTYPE_AUDIO = 2'd3;

    // header bytes kept for field extraction (length bytes travel in the token)
    localparam int HDR_STORE_DEPTH = 24;

    // transaction from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [4:0]  idx;
        logic [15:0] len;
        logic        last;
    } t_token;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/vvrd_front.sv
// ----------------------------------------------------------------------------
// vvrd_front
// sync hunt, header byte classification and payload counting, one byte a cycle
// ----------------------------------------------------------------------------
module vvrd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte_in,
    input  logic            i_abort_chunk,
    input  logic [31:0]     i_sync_word,
    input  logic [15:0]     i_max_len,
    output logic            o_tok_push,
    output vvrd_pkg::t_token o_tok
);
    import vvrd_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [7:0] FIRST_HDR_BYTE = 8'h81;
    localparam logic [4:0] IDX_FIRST      = 5'd0;
    localparam logic [4:0] IDX_FLAGS      = 5'd11;
    localparam logic [4:0] LAST_VIDEO     = 5'd25;
    localparam logic [4:0] LAST_AUDIO     = 5'd21;
    localparam logic [4:0] LENHI_VIDEO    = 5'd24;
    localparam logic [4:0] LENHI_AUDIO    = 5'd20;

    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_recent, n_recent;
    logic [4:0]  r_hidx, n_hidx;
    logic [15:0] r_rem, n_rem;
    logic [1:0]  r_dtype, n_dtype;
    logic [7:0]  r_len_hi, n_len_hi;

    logic        go_hunt;
    logic [4:0]  hdr_last;
    logic [4:0]  len_hi_idx;
    logic [15:0] frame_len;
    logic [31:0] shifted;

    assign hdr_last   = (r_dtype == DTYPE_AUDIO) ? LAST_AUDIO : LAST_VIDEO;
    assign len_hi_idx = (r_dtype == DTYPE_AUDIO) ? LENHI_AUDIO : LENHI_VIDEO;
    assign frame_len  = {r_len_hi, i_byte_in};
    assign shifted    = {r_recent[23:0], i_byte_in};

    // per-byte classification
    always_comb begin
        n_phase    = r_phase;
        n_recent   = r_recent;
        n_hidx     = r_hidx;
        n_rem      = r_rem;
        n_dtype    = r_dtype;
        n_len_hi   = r_len_hi;
        go_hunt    = 1'b0;
        o_tok_push = 1'b0;
        o_tok      = '0;
        o_tok.data = i_byte_in;
        o_tok.idx  = r_hidx;
        if (i_valid) begin
            if (i_abort_chunk) begin
                o_tok_push = (r_phase == PH_HEAD) || (r_phase == PH_BODY);
                o_tok.kind = KIND_ABORTED;
                o_tok.data = 8'd0;
                go_hunt    = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEAD: begin
                        o_tok_push = 1'b1;
                        n_hidx     = r_hidx + 5'd1;
                        if (r_hidx == IDX_FIRST && i_byte_in != FIRST_HDR_BYTE) begin
                            o_tok.kind = KIND_BAD_HDR;
                            o_tok.data = 8'd0;
                            go_hunt    = 1'b1;
                        end else if (r_hidx == IDX_FLAGS && i_byte_in[7:4] > 4'd3) begin
                            o_tok.kind = KIND_BAD_TYPE;
                            o_tok.data = 8'd0;
                            go_hunt    = 1'b1;
                        end else if (r_hidx == hdr_last) begin
                            o_tok.data = 8'd0;
                            if (frame_len > i_max_len) begin
                                o_tok.kind = KIND_TOO_LONG;
                                go_hunt    = 1'b1;
                            end else begin
                                o_tok.kind = KIND_HEADER;
                                o_tok.len  = frame_len;
                                o_tok.last = (frame_len == 16'd0);
                                if (frame_len == 16'd0) begin
                                    go_hunt = 1'b1;
                                end else begin
                                    n_phase = PH_BODY;
                                    n_hidx  = 5'd0;
                                    n_rem   = frame_len;
                                end
                            end
                        end else begin
                            o_tok.kind = TOK_HDR_BYTE;
                            if (r_hidx == IDX_FLAGS) begin
                                n_dtype = i_byte_in[5:4];
                            end
                            if (r_hidx == len_hi_idx) begin
                                n_len_hi = i_byte_in;
                            end
                        end
                    end
                    PH_BODY: begin
                        o_tok_push = 1'b1;
                        o_tok.kind = KIND_PAYLOAD;
                        o_tok.last = (r_rem <= 16'd1);
                        if (r_rem <= 16'd1) begin
                            go_hunt = 1'b1;
                        end else begin
                            n_rem = r_rem - 16'd1;
                        end
                    end
                    default: begin
                        n_phase  = PH_HUNT;
                        n_recent = shifted;
                        if (shifted == i_sync_word) begin
                            n_phase = PH_HEAD;
                            n_hidx  = 5'd0;
                            n_rem   = 16'd0;
                        end
                    end
                endcase
            end
            if (go_hunt) begin
                n_phase  = PH_HUNT;
                n_recent = 32'd0;
                n_hidx   = 5'd0;
                n_rem    = 16'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_recent <= 32'd0;
            r_hidx   <= 5'd0;
            r_rem    <= 16'd0;
            r_dtype  <= 2'd0;
            r_len_hi <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_hidx   <= n_hidx;
            r_rem    <= n_rem;
            r_dtype  <= n_dtype;
            r_len_hi <= n_len_hi;
        end
    end

endmodule

// File: rtl/vvrd_queue.sv
// ----------------------------------------------------------------------------
// vvrd_queue
// short token queue between front and back
// ----------------------------------------------------------------------------
module vvrd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vvrd_pkg::t_token i_tok,
    input  logic             i_pop,
    output vvrd_pkg::t_token o_tok,
    output vvrd_pkg::t_q_stat o_stat
);
    import vvrd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_tok        = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: rtl/vvrd_back.sv
// ----------------------------------------------------------------------------
// vvrd_back
// header byte store, record assembly and the output register
// ----------------------------------------------------------------------------
module vvrd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vvrd_pkg::t_token i_tok,
    input  vvrd_pkg::t_q_stat i_q_stat,
    output logic             o_tok_pop,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic             o_last_of_frame,
    output logic [6:0]       o_payload_type,
    output logic [15:0]      o_sequence_number,
    output logic [47:0]      o_sim_bcd,
    output logic [7:0]       o_logic_channel,
    output logic [3:0]       o_part_flag,
    output logic [1:0]       o_data_type,
    output logic [63:0]      o_timestamp,
    output logic [15:0]      o_frame_gap_ms,
    output logic [15:0]      o_data_length
);
    import vvrd_pkg::*;

    logic [7:0] r_hdr [HDR_STORE_DEPTH];
    logic       r_valid;
    logic       slot_free;
    logic       is_store;
    logic       load_out;
    logic       is_header;
    logic [1:0] hdr_dtype;

    assign slot_free = !r_valid || i_pop;
    assign is_store  = (i_tok.kind == TOK_HDR_BYTE);
    assign o_tok_pop = !i_q_stat.empty && (is_store || slot_free);
    assign load_out  = o_tok_pop && !is_store;
    assign is_header = (i_tok.kind == KIND_HEADER);
    assign hdr_dtype = r_hdr[11][5:4];
    assign o_valid   = r_valid;

    // header bytes land at their header offset
    always_ff @(posedge i_clk) begin
        if (o_tok_pop && is_store && i_tok.idx < 5'(HDR_STORE_DEPTH)) begin
            r_hdr[i_tok.idx] <= i_tok.data;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_kind          <= i_tok.kind;
            o_byte_value    <= (i_tok.kind == KIND_PAYLOAD) ? i_tok.data : 8'd0;
            o_last_of_frame <= i_tok.last;
            if (is_header) begin
                o_payload_type    <= r_hdr[1][6:0];
                o_sequence_number <= {r_hdr[2], r_hdr[3]};
                o_sim_bcd         <= {r_hdr[4], r_hdr[5], r_hdr[6],
                                      r_hdr[7], r_hdr[8], r_hdr[9]};
                o_logic_channel   <= r_hdr[10];
                o_part_flag       <= r_hdr[11][3:0];
                o_data_type       <= hdr_dtype;
                o_timestamp       <= {r_hdr[12], r_hdr[13], r_hdr[14], r_hdr[15],
                                      r_hdr[16], r_hdr[17], r_hdr[18], r_hdr[19]};
                o_frame_gap_ms    <= (hdr_dtype == DTYPE_AUDIO) ? 16'd0
                                                                : {r_hdr[22], r_hdr[23]};
                o_data_length     <= i_tok.len;
            end else begin
                o_payload_type    <= 7'd0;
                o_sequence_number <= 16'd0;
                o_sim_bcd         <= 48'd0;
                o_logic_channel   <= 8'd0;
                o_part_flag       <= 4'd0;
                o_data_type       <= 2'd0;
                o_timestamp       <= 64'd0;
                o_frame_gap_ms    <= 16'd0;
                o_data_length     <= 16'd0;
            end
        end
    end

    // output occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_out) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/vehicle_video_rtp_deframer_core.sv
// ----------------------------------------------------------------------------
// vehicle_video_rtp_deframer_core
// rtp style video/audio frame deframer: sync hunt, header record, payload bytes
// path: the token of a taken byte is written into the token queue, and the back end
// moves it from there into the output register
// throughput: one byte per cycle while full is low, set by the single-byte front parser step
// full rises only when the token queue fills under output back-pressure
// reset: synchronous active-low i_rst_n; back to sync hunt, queue and output empty
// ----------------------------------------------------------------------------
module vehicle_video_rtp_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    input  logic        i_abort_chunk,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_last_of_frame,
    output logic [6:0]  o_payload_type,
    output logic [15:0] o_sequence_number,
    output logic [47:0] o_sim_bcd,
    output logic [7:0]  o_logic_channel,
    output logic [3:0]  o_part_flag,
    output logic [1:0]  o_data_type,
    output logic [63:0] o_timestamp,
    output logic [15:0] o_frame_gap_ms,
    output logic [15:0] o_data_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import vvrd_pkg::*;

    `include "vehicle_video_rtp_deframer_core_macros.svh"

    logic [31:0] r_sync_word;
    logic [15:0] r_max_len;
    logic        fe_valid;
    logic        fe_push;
    t_token      fe_tok;
    t_token      q_tok;
    t_q_stat     q_stat;
    logic        be_pop;
    logic        be_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_WORD_RST;
            r_max_len   <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_WORD: r_sync_word <= i_cfg_data;
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data[15:0];
                default:       r_max_len   <= r_max_len;
            endcase
        end
    end

    // input transaction
    assign full     = q_stat.full;
    assign fe_valid = push && !q_stat.full;
    assign empty    = !be_valid;

    // front parser
    vvrd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fe_valid),
        .i_byte_in     (i_byte_in),
        .i_abort_chunk (i_abort_chunk),
        .i_sync_word   (r_sync_word),
        .i_max_len     (r_max_len),
        .o_tok_push    (fe_push),
        .o_tok         (fe_tok)
    );

    // decoupling queue
    vvrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_tok   (fe_tok),
        .i_pop   (be_pop),
        .o_tok   (q_tok),
        .o_stat  (q_stat)
    );

    // record assembly and output
    vvrd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tok             (q_tok),
        .i_q_stat          (q_stat),
        .o_tok_pop         (be_pop),
        .i_pop             (pop),
        .o_valid           (be_valid),
        .o_kind            (o_kind),
        .o_byte_value      (o_byte_value),
        .o_last_of_frame   (o_last_of_frame),
        .o_payload_type    (o_payload_type),
        .o_sequence_number (o_sequence_number),
        .o_sim_bcd         (o_sim_bcd),
        .o_logic_channel   (o_logic_channel),
        .o_part_flag       (o_part_flag),
        .o_data_type       (o_data_type),
        .o_timestamp       (o_timestamp),
        .o_frame_gap_ms    (o_frame_gap_ms),
        .o_data_length     (o_data_length)
    );

    // front never writes a token that the queue cannot take
    `VVRD_ASSERT_IMPLY(a_no_push_when_full, fe_push, !q_stat.full)
    // non-payload results carry a zero byte value
    `VVRD_ASSERT_IMPLY(a_zero_byte_value, !empty && o_kind != KIND_PAYLOAD, o_byte_value == 8'd0)
    // nothing shows up at the output without a queued transaction
    `VVRD_ASSERT_NEXT(a_no_spurious_result, empty && q_stat.empty, empty)

endmodule
